// ===== hw/rtl/xml_char_tokenizer_macros.svh =====
// Assertion macros for the tokenizer checker.
`ifndef XML_CHAR_TOKENIZER_MACROS_SVH
`define XML_CHAR_TOKENIZER_MACROS_SVH

// Checked only outside reset.
`define XCT_CHECK(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("xct check failed");

// Checked at every edge, reset included.
`define XCT_CHECK_RST(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("xct reset check failed");

`endif

// ===== hw/rtl/xct_pkg.sv =====
`default_nettype none
package xct_pkg;

    typedef enum logic [2:0] {
        MODE_NORMAL,
        MODE_ESTART,
        MODE_ATTR,
        MODE_AVAL,
        MODE_EVAL
    } mode_t;

    typedef enum logic [2:0] {
        TOK_NONE,
        TOK_ENAME,
        TOK_EVALUE,
        TOK_ANAME,
        TOK_AVALUE
    } tok_t;

    typedef enum logic [3:0] {
        KIND_LT,
        KIND_SLASH,
        KIND_GT,
        KIND_QUOTE,
        KIND_EQ,
        KIND_ENAME,
        KIND_EVALUE,
        KIND_ANAME,
        KIND_AVALUE,
        KIND_END
    } kind_t;

    localparam int MaxRes = 3;

    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef struct packed {
        kind_t      kind;
        logic       has_char;
        logic [7:0] ch;
        logic       start;
        logic       stop;
        logic       err;
    } res_t;

    // All results caused by one input beat.
    typedef struct packed {
        logic [1:0]              cnt;
        res_t [MaxRes-1:0]       res;
    } entry_t;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A)
            || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    function automatic kind_t kind_of(input tok_t t);
        kind_t k;
        case (t)
            TOK_ENAME:  k = KIND_ENAME;
            TOK_EVALUE: k = KIND_EVALUE;
            TOK_ANAME:  k = KIND_ANAME;
            default:    k = KIND_AVALUE;
        endcase
        return k;
    endfunction

    function automatic res_t mk_res(input kind_t kind, input logic has_char,
                                    input logic [7:0] ch, input logic start,
                                    input logic stop, input logic err);
        res_t r;
        r.kind     = kind;
        r.has_char = has_char;
        r.ch       = ch;
        r.start    = start;
        r.stop     = stop;
        r.err      = err;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/xct_front.sv =====
`default_nettype none
module xct_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire logic [7:0]     s_char_in,
    input  wire logic           s_end_of_input,
    input  wire logic           q_full,
    output logic                q_push,
    output xct_pkg::entry_t     q_entry
);
    import xct_pkg::*;

    mode_t      mode_reg, mode_next;
    tok_t       tok_reg, tok_next;
    logic       err_reg, err_next;
    logic [1:0] n;
    logic       handled;
    logic       cont;
    logic [7:0] c;
    logic       eoi;
    logic       accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign c       = s_char_in;
    assign eoi     = s_end_of_input;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NORMAL;
            tok_reg  <= TOK_NONE;
            err_reg  <= 1'b0;
        end else if (accept) begin
            mode_reg <= mode_next;
            tok_reg  <= tok_next;
            err_reg  <= err_next;
        end
    end

    always_comb begin
        mode_next = mode_reg;
        tok_next  = tok_reg;
        err_next  = err_reg;
        q_entry   = '0;
        n         = 2'd0;
        handled   = 1'b0;
        cont      = 1'b0;
        if (!err_reg) begin
            if (tok_reg != TOK_NONE) begin
                case (tok_reg)
                    TOK_ENAME:  cont = is_alnum(c) || c == CH_USCORE;
                    TOK_ANAME:  cont = is_alnum(c) || c == CH_COLON;
                    TOK_EVALUE: cont = c != CH_LT;
                    default:    cont = c != CH_QUOTE;
                endcase
                if (cont) begin
                    q_entry.res[n] = mk_res(kind_of(tok_reg), 1'b1, c, 1'b0, eoi, 1'b0);
                    handled = 1'b1;
                end else begin
                    q_entry.res[n] = mk_res(kind_of(tok_reg), 1'b0, 8'h00, 1'b0, 1'b1,
                                            1'b0);
                    tok_next = TOK_NONE;
                end
                n = n + 2'd1;
            end
            if (!handled && !is_space(c)) begin
                if (c == CH_LT) begin
                    q_entry.res[n] = mk_res(KIND_LT, 1'b1, c, 1'b1, 1'b1, 1'b0);
                    mode_next = MODE_ESTART;
                    n = n + 2'd1;
                end else if (c == CH_GT) begin
                    q_entry.res[n] = mk_res(KIND_GT, 1'b1, c, 1'b1, 1'b1, 1'b0);
                    mode_next = MODE_EVAL;
                    n = n + 2'd1;
                end else if (c == CH_SLASH) begin
                    q_entry.res[n] = mk_res(KIND_SLASH, 1'b1, c, 1'b1, 1'b1, 1'b0);
                    mode_next = MODE_NORMAL;
                    n = n + 2'd1;
                end else if (c == CH_EQ) begin
                    q_entry.res[n] = mk_res(KIND_EQ, 1'b1, c, 1'b1, 1'b1, 1'b0);
                    mode_next = MODE_AVAL;
                    n = n + 2'd1;
                end else if (c == CH_QUOTE) begin
                    q_entry.res[n] = mk_res(KIND_QUOTE, 1'b1, c, 1'b1, 1'b1, 1'b0);
                    n = n + 2'd1;
                end else if (mode_reg == MODE_EVAL) begin
                    tok_next = TOK_EVALUE;
                    q_entry.res[n] = mk_res(KIND_EVALUE, 1'b1, c, 1'b1, eoi, 1'b0);
                    n = n + 2'd1;
                end else if (is_alnum(c) || c == CH_COLON || c == CH_USCORE) begin
                    case (mode_reg)
                        MODE_ESTART: begin
                            mode_next = MODE_ATTR;
                            tok_next  = TOK_ENAME;
                        end
                        MODE_ATTR: begin
                            mode_next = MODE_AVAL;
                            tok_next  = TOK_ANAME;
                        end
                        MODE_AVAL: begin
                            mode_next = MODE_ATTR;
                            tok_next  = TOK_AVALUE;
                        end
                        default: begin
                            mode_next = MODE_NORMAL;
                            tok_next  = TOK_ENAME;
                        end
                    endcase
                    q_entry.res[n] = mk_res(kind_of(tok_next), 1'b1, c, 1'b1, eoi, 1'b0);
                    n = n + 2'd1;
                end else if (!eoi) begin
                    q_entry.res[n] = mk_res(KIND_END, 1'b1, c, 1'b0, 1'b0, 1'b1);
                    err_next = 1'b1;
                    tok_next = TOK_NONE;
                    n = n + 2'd1;
                end
            end
        end
        if (eoi) begin
            q_entry.res[n] = mk_res(KIND_END, 1'b0, 8'h00, 1'b0, 1'b1, err_reg);
            n = n + 2'd1;
            mode_next = MODE_NORMAL;
            tok_next  = TOK_NONE;
            err_next  = 1'b0;
        end
        q_entry.cnt = n;
    end

    assign q_push = accept && (n != 2'd0);

endmodule
`default_nettype wire

// ===== hw/rtl/xct_fifo.sv =====
`default_nettype none
module xct_fifo (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire xct_pkg::entry_t push_entry,
    input  wire logic           pop,
    output xct_pkg::entry_t     pop_entry,
    output logic                empty,
    output logic                full
);
    import xct_pkg::*;

    entry_t     mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign empty     = count_reg == 2'd0;
    assign full      = count_reg == 2'd2;
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/xct_back.sv =====
`default_nettype none
module xct_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_empty,
    input  wire xct_pkg::entry_t q_entry,
    output logic                q_pop,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic [3:0]          m_token_kind,
    output logic                m_has_char,
    output logic [7:0]          m_char_out,
    output logic                m_token_start,
    output logic                m_token_end,
    output logic                m_lex_error,
    output logic                m_last_of_run
);
    import xct_pkg::*;

    entry_t     cur_reg;
    logic [1:0] idx_reg;
    logic       valid_reg;
    logic       last;
    res_t       sel;

    assign last  = idx_reg == (cur_reg.cnt - 2'd1);
    assign q_pop = !q_empty && (!valid_reg || (m_ready && last));
    assign sel   = cur_reg.res[idx_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end else if (valid_reg && m_ready) begin
            if (last) begin
                valid_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_entry;
        end
    end

    assign m_valid       = valid_reg;
    assign m_token_kind  = sel.kind;
    assign m_has_char    = sel.has_char;
    assign m_char_out    = sel.ch;
    assign m_token_start = sel.start;
    assign m_token_end   = sel.stop;
    assign m_lex_error   = sel.err;
    assign m_last_of_run = last;

endmodule
`default_nettype wire

// ===== hw/rtl/xml_char_tokenizer.sv =====
// XML character tokenizer.
// Input channel (s_): one byte of text per beat, s_end_of_input on the final
// byte of a document. Result channel (m_): one token result per beat, with
// kind, character, start/end marks, error flag and m_last_of_run on the
// final result that an input byte causes. A byte yields zero to three results.
// The front end classifies each byte in the cycle it is accepted and pushes
// its whole result group into a two-entry queue; the back end plays a group
// out one result per cycle while m_ready is high, from its output register.
// A result passes through the queue and the output register before m_valid.
// Throughput: with m_ready high, one byte per cycle while each byte yields at most
// one result; otherwise the single result port sets the pace, one result per cycle.
// If the receiver stalls, the back end holds its result and the queue fills;
// s_ready falls once both queue entries are taken.
// Reset (aresetn low, synchronous) returns the lexer to normal mode with no
// open token, clears the error flag and empties the queue and output stage.
`default_nettype none
module xml_char_tokenizer (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_char_in,
    input  wire logic       s_end_of_input,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [3:0]      m_token_kind,
    output logic            m_has_char,
    output logic [7:0]      m_char_out,
    output logic            m_token_start,
    output logic            m_token_end,
    output logic            m_lex_error,
    output logic            m_last_of_run
);
    import xct_pkg::*;

    entry_t push_entry;
    entry_t pop_entry;
    logic   push;
    logic   pop;
    logic   empty;
    logic   full;

    xct_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_in      (s_char_in),
        .s_end_of_input (s_end_of_input),
        .q_full         (full),
        .q_push         (push),
        .q_entry        (push_entry)
    );

    xct_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (empty),
        .full       (full)
    );

    xct_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (empty),
        .q_entry       (pop_entry),
        .q_pop         (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_token_kind  (m_token_kind),
        .m_has_char    (m_has_char),
        .m_char_out    (m_char_out),
        .m_token_start (m_token_start),
        .m_token_end   (m_token_end),
        .m_lex_error   (m_lex_error),
        .m_last_of_run (m_last_of_run)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/xct_checker.sv =====
`default_nettype none
`include "xml_char_tokenizer_macros.svh"
module xct_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [3:0] m_token_kind,
    input wire logic       m_has_char,
    input wire logic [7:0] m_char_out,
    input wire logic       m_token_start,
    input wire logic       m_token_end,
    input wire logic       m_lex_error,
    input wire logic       m_last_of_run
);
    import xct_pkg::*;

    `XCT_CHECK_RST(a_reset_empty, !aresetn |=> !m_valid)
    `XCT_CHECK(a_hold_valid, m_valid && !m_ready |=> m_valid)
    `XCT_CHECK(a_hold_data, m_valid && !m_ready |=> $stable({m_token_kind, m_char_out, m_last_of_run}))
    `XCT_CHECK(a_marker_no_char, m_valid && !m_has_char |-> m_char_out == 8'h00 && !m_token_start && m_token_end)
    `XCT_CHECK(a_error_is_end, m_valid && m_lex_error |-> m_token_kind == KIND_END)

endmodule

bind xml_char_tokenizer xct_checker u_xct_checker (.*);
`default_nettype wire

// ===== dv/xml_char_tokenizer_tb.sv =====
`timescale 1ns / 100ps

module xml_char_tokenizer_tb;
    import xct_pkg::*;

    localparam int HOLD_CYCLES = 120;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [3:0] kind;
        logic       has_ch;
        logic [7:0] ch;
        logic       first;
        logic       closes;
        logic       err;
        logic       last;
    } tok_beat_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_char_in = 8'h00;
    logic       s_end_of_input = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [3:0] m_token_kind;
    logic       m_has_char;
    logic [7:0] m_char_out;
    logic       m_token_start;
    logic       m_token_end;
    logic       m_lex_error;
    logic       m_last_of_run;

    mode_t      lx_mode = MODE_NORMAL;
    tok_t       lx_tok = TOK_NONE;
    logic       lx_err = 1'b0;

    tok_beat_t  token_beats_due[$];
    logic [7:0] text_q[$];
    int         bad_beats = 0;
    int         bytes_sent = 0;
    int         cycles = 0;
    int         rx_wait = 0;
    bit         tx_idle_en = 1'b1;
    bit         rx_idle_en = 1'b1;
    bit         hold_req = 1'b0;
    bit         holding = 1'b0;

    xml_char_tokenizer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_in      (s_char_in),
        .s_end_of_input (s_end_of_input),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_kind   (m_token_kind),
        .m_has_char     (m_has_char),
        .m_char_out     (m_char_out),
        .m_token_start  (m_token_start),
        .m_token_end    (m_token_end),
        .m_lex_error    (m_lex_error),
        .m_last_of_run  (m_last_of_run)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] rand_alnum();
        int r;
        r = $urandom_range(0, 61);
        if (r < 10) return 8'(8'h30 + r);
        if (r < 36) return 8'(8'h41 + r - 10);
        return 8'(8'h61 + r - 36);
    endfunction

    function automatic logic [7:0] rand_print(input logic [7:0] stop);
        logic [7:0] c;
        do c = 8'($urandom_range(32, 126)); while (c == stop);
        return c;
    endfunction

    function automatic logic [7:0] ws_ch();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic tok_beat_t tok_res(input kind_t k, input logic h, input logic [7:0] c,
                                          input logic s, input logic e, input logic er);
        tok_beat_t b;
        b.kind   = k;
        b.has_ch = h;
        b.ch     = c;
        b.first  = s;
        b.closes = e;
        b.err    = er;
        b.last   = 1'b0;
        return b;
    endfunction

    // Token beats caused by one accepted byte, appended to token_beats_due.
    task automatic lex_byte(input logic [7:0] c, input logic eoi);
        tok_beat_t grp[$];
        mode_t     md;
        tok_t      tk;
        kind_t     ok;
        logic      alnum, blank, more, took;
        md    = lx_mode;
        tk    = lx_tok;
        took  = 1'b0;
        more  = 1'b0;
        alnum = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
        blank = c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
        case (tk)
            TOK_ENAME:  ok = KIND_ENAME;
            TOK_EVALUE: ok = KIND_EVALUE;
            TOK_ANAME:  ok = KIND_ANAME;
            default:    ok = KIND_AVALUE;
        endcase
        if (!lx_err) begin
            if (tk != TOK_NONE) begin
                case (tk)
                    TOK_ENAME:  more = alnum || c == CH_USCORE;
                    TOK_ANAME:  more = alnum || c == CH_COLON;
                    TOK_EVALUE: more = c != CH_LT;
                    default:    more = c != CH_QUOTE;
                endcase
                if (more) begin
                    grp.insert(grp.size(), tok_res(ok, 1'b1, c, 1'b0, eoi, 1'b0));
                    took = 1'b1;
                end else begin
                    grp.insert(grp.size(), tok_res(ok, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0));
                    tk = TOK_NONE;
                end
            end
            if (!took && !blank) begin
                if (c == CH_LT) begin
                    grp.insert(grp.size(), tok_res(KIND_LT, 1'b1, c, 1'b1, 1'b1, 1'b0));
                    md = MODE_ESTART;
                end else if (c == CH_GT) begin
                    grp.insert(grp.size(), tok_res(KIND_GT, 1'b1, c, 1'b1, 1'b1, 1'b0));
                    md = MODE_EVAL;
                end else if (c == CH_SLASH) begin
                    grp.insert(grp.size(), tok_res(KIND_SLASH, 1'b1, c, 1'b1, 1'b1, 1'b0));
                    md = MODE_NORMAL;
                end else if (c == CH_EQ) begin
                    grp.insert(grp.size(), tok_res(KIND_EQ, 1'b1, c, 1'b1, 1'b1, 1'b0));
                    md = MODE_AVAL;
                end else if (c == CH_QUOTE) begin
                    grp.insert(grp.size(), tok_res(KIND_QUOTE, 1'b1, c, 1'b1, 1'b1, 1'b0));
                end else if (md == MODE_EVAL) begin
                    tk = TOK_EVALUE;
                    grp.insert(grp.size(), tok_res(KIND_EVALUE, 1'b1, c, 1'b1, eoi, 1'b0));
                end else if (alnum || c == CH_COLON || c == CH_USCORE) begin
                    case (md)
                        MODE_ESTART: begin
                            md = MODE_ATTR;
                            tk = TOK_ENAME;
                            ok = KIND_ENAME;
                        end
                        MODE_ATTR: begin
                            md = MODE_AVAL;
                            tk = TOK_ANAME;
                            ok = KIND_ANAME;
                        end
                        MODE_AVAL: begin
                            md = MODE_ATTR;
                            tk = TOK_AVALUE;
                            ok = KIND_AVALUE;
                        end
                        default: begin
                            md = MODE_NORMAL;
                            tk = TOK_ENAME;
                            ok = KIND_ENAME;
                        end
                    endcase
                    grp.insert(grp.size(), tok_res(ok, 1'b1, c, 1'b1, eoi, 1'b0));
                end else if (!eoi) begin
                    grp.insert(grp.size(), tok_res(KIND_END, 1'b1, c, 1'b0, 1'b0, 1'b1));
                    lx_err = 1'b1;
                    tk = TOK_NONE;
                end
            end
        end
        lx_mode = md;
        lx_tok  = tk;
        if (eoi) begin
            grp.insert(grp.size(), tok_res(KIND_END, 1'b0, 8'h00, 1'b0, 1'b1, lx_err));
            lx_mode = MODE_NORMAL;
            lx_tok  = TOK_NONE;
            lx_err  = 1'b0;
        end
        if (grp.size() != 0) grp[grp.size() - 1].last = 1'b1;
        foreach (grp[i]) token_beats_due.insert(token_beats_due.size(), grp[i]);
    endtask

    always @(posedge aclk) begin : chk_beat
        tok_beat_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got.kind   = m_token_kind;
            got.has_ch = m_has_char;
            got.ch     = m_char_out;
            got.first  = m_token_start;
            got.closes = m_token_end;
            got.err    = m_lex_error;
            got.last   = m_last_of_run;
            if (token_beats_due.size() == 0) begin
                bad_beats++;
                if (bad_beats <= 10)
                    $display("%0t: token beat with none due: kind %0d char %h", $time,
                             got.kind, got.ch);
            end else begin
                want = token_beats_due.pop_front();
                if (got !== want) begin
                    bad_beats++;
                    if (bad_beats <= 10)
                        $display("%0t: kind %0d/%0d has %b/%b char %h/%h start %b/%b end %b/%b %s",
                                 $time, want.kind, got.kind, want.has_ch, got.has_ch,
                                 want.ch, got.ch, want.first, got.first, want.closes,
                                 got.closes, $sformatf("err %b/%b last %b/%b (exp/got)",
                                 want.err, got.err, want.last, got.last));
                end
            end
        end
    end

    // Receiver: random stalls plus one long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (hold_req && !holding) begin
                holding = 1'b1;
                rx_wait = HOLD_CYCLES;
            end else if (rx_wait == 0 && rx_idle_en && $urandom_range(0, 3) == 0) begin
                rx_wait = idle_len();
            end
            if (rx_wait > 0) begin
                m_ready <= 1'b0;
                rx_wait--;
            end else begin
                m_ready <= 1'b1;
                if (holding) begin
                    holding  = 1'b0;
                    hold_req = 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_beat(input logic [7:0] c, input logic eoi);
        int gap;
        gap = tx_idle_en ? idle_len() : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_char_in      <= c;
        s_end_of_input <= eoi;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        lex_byte(c, eoi);
        bytes_sent++;
    endtask

    task automatic send_str(input string s, input logic eoi_at_end);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], eoi_at_end && i == s.len() - 1);
    endtask

    task automatic send_txt();
        foreach (text_q[i]) send_beat(text_q[i], i == text_q.size() - 1);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (token_beats_due.size() != 0);
    endtask

    task automatic make_doc();
        logic [7:0] nm[$];
        text_q.delete();
        repeat ($urandom_range(1, 2)) begin
            if ($urandom_range(0, 2) == 0) text_q.insert(text_q.size(), ws_ch());
            text_q.insert(text_q.size(), CH_LT);
            nm.delete();
            nm.insert(nm.size(), $urandom_range(0, 7) == 0 ? CH_USCORE : rand_alnum());
            repeat ($urandom_range(0, 3))
                nm.insert(nm.size(), $urandom_range(0, 5) == 0 ? CH_USCORE : rand_alnum());
            foreach (nm[i]) text_q.insert(text_q.size(), nm[i]);
            repeat ($urandom_range(0, 2)) begin
                text_q.insert(text_q.size(), ws_ch());
                text_q.insert(text_q.size(), rand_alnum());
                repeat ($urandom_range(0, 3))
                    text_q.insert(text_q.size(),
                                  $urandom_range(0, 5) == 0 ? CH_COLON : rand_alnum());
                text_q.insert(text_q.size(), CH_EQ);
                text_q.insert(text_q.size(), CH_QUOTE);
                if ($urandom_range(0, 5) != 0) begin
                    text_q.insert(text_q.size(), rand_alnum());
                    repeat ($urandom_range(0, 4))
                        text_q.insert(text_q.size(), rand_print(CH_QUOTE));
                end
                text_q.insert(text_q.size(), CH_QUOTE);
            end
            if ($urandom_range(0, 4) == 0) begin
                text_q.insert(text_q.size(), CH_SLASH);
                text_q.insert(text_q.size(), CH_GT);
            end else begin
                text_q.insert(text_q.size(), CH_GT);
                repeat ($urandom_range(0, 6)) text_q.insert(text_q.size(), rand_print(CH_LT));
                text_q.insert(text_q.size(), CH_LT);
                text_q.insert(text_q.size(), CH_SLASH);
                foreach (nm[i]) text_q.insert(text_q.size(), nm[i]);
                text_q.insert(text_q.size(), CH_GT);
            end
        end
    endtask

    task automatic test_directed();
        // names, attribute, quoted value, element value ended by end of input
        send_str("<a x:=\"1\">v\tw", 1'b1);
        // close tag, high byte value, bad byte in a tag, bytes dropped after it
        send_str("</Q>", 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(CH_LT, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat("z", 1'b0);
        send_beat(CH_GT, 1'b1);
        // close marker, slash and end marker from one byte
        send_str(":/", 1'b1);
        // bad final byte is dropped silently
        send_beat(CH_USCORE, 1'b0);
        send_beat(8'h80, 1'b1);
    endtask

    task automatic test_no_idle();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        make_doc();
        send_txt();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_output_hold();
        hold_req = 1'b1;
        wait (holding);
        tx_idle_en = 1'b0;
        make_doc();
        send_txt();
        tx_idle_en = 1'b1;
    endtask

    task automatic test_drain_pause();
        int k;
        repeat (2) begin
            make_doc();
            k = text_q.size() / 2;
            foreach (text_q[i]) begin
                if (i == k) wait_drained();
                send_beat(text_q[i], i == text_q.size() - 1);
            end
        end
    endtask

    task automatic test_well_formed();
        int stop_at, pick, k;
        stop_at = bytes_sent + 50;
        while (bytes_sent < stop_at) begin
            make_doc();
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                k = $urandom_range(1, text_q.size());
                while (text_q.size() > k) text_q.delete(text_q.size() - 1);
            end else if (pick == 1) begin
                text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
            end
            send_txt();
        end
    endtask

    task automatic test_noise();
        int stop_at;
        stop_at = bytes_sent + 25;
        while (bytes_sent < stop_at) begin
            text_q.delete();
            repeat ($urandom_range(1, 8)) begin
                case ($urandom_range(0, 2))
                    0:       text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
                    1:       text_q.insert(text_q.size(), ws_ch());
                    default: text_q.insert(text_q.size(), 8'($urandom_range(32, 126)));
                endcase
            end
            send_txt();
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_no_idle();
        test_output_hold();
        test_drain_pause();
        test_well_formed();
        test_noise();
        wait_drained();
        repeat (20) @(posedge aclk);
        if (bad_beats == 0 && token_beats_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
